### sv/lcd_dp_pkg.sv
// Shared types, sizes, command codes and contrast tables for the LCD
// controller command and data port. No dependencies.
package lcd_dp_pkg;

   // Display RAM geometry.
   localparam int PAGE_COUNT  = 9;
   localparam int PAGE_STRIDE = 256;
   localparam int RAM_DEPTH   = PAGE_COUNT * PAGE_STRIDE;
   localparam int RAM_AW      = $clog2(RAM_DEPTH);
   localparam logic [7:0] LAST_COLUMN = 8'd131;

   // Command codes and ranges.
   localparam logic [7:0] CMD_COL_LO_FIRST  = 8'h00;
   localparam logic [7:0] CMD_COL_LO_LAST   = 8'h0F;
   localparam logic [7:0] CMD_COL_HI_FIRST  = 8'h10;
   localparam logic [7:0] CMD_COL_HI_LAST   = 8'h1F;
   localparam logic [7:0] CMD_START_FIRST   = 8'h40;
   localparam logic [7:0] CMD_START_LAST    = 8'h7F;
   localparam logic [7:0] CMD_CONTRAST      = 8'h81;
   localparam logic [7:0] CMD_SEG_NORMAL    = 8'hA0;
   localparam logic [7:0] CMD_SEG_REVERSE   = 8'hA1;
   localparam logic [7:0] CMD_MAX_OFF       = 8'hA2;
   localparam logic [7:0] CMD_MAX_ON        = 8'hA3;
   localparam logic [7:0] CMD_SET_OFF       = 8'hA4;
   localparam logic [7:0] CMD_SET_ON        = 8'hA5;
   localparam logic [7:0] CMD_INV_OFF       = 8'hA6;
   localparam logic [7:0] CMD_INV_ON        = 8'hA7;
   localparam logic [7:0] CMD_DISP_OFF      = 8'hAE;
   localparam logic [7:0] CMD_DISP_ON       = 8'hAF;
   localparam logic [7:0] CMD_PAGE_FIRST    = 8'hB0;
   localparam logic [7:0] CMD_PAGE_LAST     = 8'hB8;
   localparam logic [7:0] CMD_ROWS_FIRST    = 8'hC0;
   localparam logic [7:0] CMD_ROWS_LAST     = 8'hCF;
   localparam logic [7:0] CMD_RMW_START     = 8'hE0;
   localparam logic [7:0] CMD_SOFT_RESET    = 8'hE2;
   localparam logic [7:0] CMD_RMW_END       = 8'hEE;

   // Fixed values.
   localparam logic [5:0] CONTRAST_RESET    = 6'h1F;
   localparam logic [5:0] CONTRAST_SOFT     = 6'h20;
   localparam logic [5:0] CONTRAST_FULL     = 6'h3F;
   localparam logic [7:0] MAX_LIGHT         = 8'd240;
   localparam logic [7:0] MAX_DARK          = 8'd255;
   localparam logic [7:0] STATUS_BASE       = 8'h40;
   localparam logic [7:0] STATUS_ON         = 8'h20;
   localparam logic [7:0] HELD_RESET        = 8'h40;
   localparam logic [7:0] MASK_ALL          = 8'hFF;
   localparam logic [7:0] MASK_ICON_PAGE    = 8'h01;
   localparam logic [7:0] MASK_NONE         = 8'h00;

   localparam logic [7:0] LIGHT_TABLE [64] = '{
      8'd0,   8'd0,   8'd1,   8'd1,   8'd2,   8'd2,   8'd3,   8'd3,
      8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,
      8'd8,   8'd8,   8'd9,   8'd9,   8'd10,  8'd10,  8'd11,  8'd11,
      8'd12,  8'd12,  8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,
      8'd22,  8'd30,  8'd37,  8'd45,  8'd52,  8'd60,  8'd67,  8'd75,
      8'd82,  8'd90,  8'd97,  8'd105, 8'd112, 8'd120, 8'd127, 8'd135,
      8'd142, 8'd150, 8'd157, 8'd165, 8'd172, 8'd180, 8'd187, 8'd195,
      8'd202, 8'd210, 8'd217, 8'd225, 8'd232, 8'd240, 8'd247, 8'd255
   };

   localparam logic [7:0] DARK_TABLE [64] = '{
      8'd0,   8'd7,   8'd15,  8'd22,  8'd30,  8'd37,  8'd45,  8'd52,
      8'd60,  8'd67,  8'd75,  8'd82,  8'd90,  8'd97,  8'd105, 8'd112,
      8'd120, 8'd127, 8'd135, 8'd142, 8'd150, 8'd157, 8'd165, 8'd172,
      8'd180, 8'd187, 8'd195, 8'd202, 8'd210, 8'd217, 8'd225, 8'd232,
      8'd240, 8'd241, 8'd241, 8'd242, 8'd242, 8'd243, 8'd243, 8'd244,
      8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd247, 8'd248,
      8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd251, 8'd251, 8'd252,
      8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255
   };

   // Display RAM access issued by the core.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        wdata;
   } ram_req_type;

   // Display mode flags.
   typedef struct packed {
      logic rows;
      logic on;
      logic inv;
      logic set;
      logic seg;
   } mode_type;

   typedef struct packed {
      logic [7:0] light;
      logic [7:0] dark;
   } levels_type;

   // Pixel levels for a contrast value, or the fixed pair in max contrast mode.
   function automatic levels_type contrast_levels(input logic max_flag,
                                                  input logic [5:0] value);
      levels_type lv;
      if (max_flag) begin
         lv.light = MAX_LIGHT;
         lv.dark  = MAX_DARK;
      end else begin
         lv.light = LIGHT_TABLE[value];
         lv.dark  = DARK_TABLE[value];
      end
      return lv;
   endfunction

endpackage

### sv/lcd_dp_ram.sv
// Display RAM with a registered read port and a zero fill sweep after reset.
// Depends on lcd_dp_pkg for geometry and the request struct.
module lcd_dp_ram (
   input  logic                     clock,
   input  logic                     reset,
   input  lcd_dp_pkg::ram_req_type  req,
   output logic [7:0]               rd_data,
   output logic                     ready
);

   logic [7:0]                    mem_ff [lcd_dp_pkg::RAM_DEPTH];
   logic [7:0]                    rd_data_ff;
   logic                          clear_busy_ff;
   logic                          clear_busy_in;
   logic [lcd_dp_pkg::RAM_AW-1:0] clear_addr_ff;
   logic [lcd_dp_pkg::RAM_AW-1:0] clear_addr_in;

   // The sweep walks every entry once, one per cycle.
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == lcd_dp_pkg::RAM_AW'(lcd_dp_pkg::RAM_DEPTH - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   // Storage: the sweep has the write port until it is done.
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem_ff[clear_addr_ff] <= 8'h00;
      end else if (req.wr_en) begin
         mem_ff[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem_ff[req.addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign ready   = ~clear_busy_ff;

endmodule

### sv/lcd_dp_core.sv
// Command decode, pointer and mode registers, contrast logic and read byte
// handling for one bus access. Depends on lcd_dp_pkg; drives lcd_dp_ram.
module lcd_dp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic                     op,
   input  logic                     reg_sel,
   input  logic [7:0]               wdata,
   input  logic                     cpu_access,
   input  logic [7:0]               ram_rd_data,
   output lcd_dp_pkg::ram_req_type  ram_req,
   output logic [7:0]               rdata,
   output logic [5:0]               contrast_level,
   output logic [7:0]               light_level,
   output logic [7:0]               dark_level,
   output logic                     display_enabled,
   output logic [5:0]               first_line,
   output logic                     segment_reversed,
   output logic                     rows_reversed,
   output logic                     invert_all,
   output logic                     force_all
);

   logic [7:0]           column_ff,   column_in;
   logic [3:0]           page_ff,     page_in;
   logic [5:0]           start_ff,    start_in;
   logic [5:0]           contrast_ff, contrast_in;
   logic [7:0]           light_ff,    light_in;
   logic [7:0]           dark_ff,     dark_in;
   logic                 pending_ff,  pending_in;
   logic                 max_ff,      max_in;
   lcd_dp_pkg::mode_type mode_ff,     mode_in;
   logic                 rmw_ff,      rmw_in;
   logic [7:0]           saved_ff,    saved_in;
   logic                 dummy_ff,    dummy_in;
   logic [7:0]           held_ff,     held_in;
   logic                 held_src_ff, held_src_in;
   logic [7:0]           mask_ff,     mask_in;
   logic [7:0]           rdata_ff,    rdata_in;
   logic                 rd_ram_ff,   rd_ram_in;

   logic                   page_valid;
   logic [7:0]             addr_col;
   logic [7:0]             col_next;
   logic [7:0]             col_step;
   logic [7:0]             held_now;
   lcd_dp_pkg::levels_type lv;

   // Address and pointer helpers.
   assign page_valid = {1'b0, page_ff} < 5'(lcd_dp_pkg::PAGE_COUNT);
   assign addr_col   = mode_ff.seg ? (lcd_dp_pkg::LAST_COLUMN - column_ff) : column_ff;
   assign col_step   = column_ff + 8'd1;
   assign col_next   = (col_step > lcd_dp_pkg::LAST_COLUMN) ? lcd_dp_pkg::LAST_COLUMN
                                                           : col_step;
   // The held byte may still be the last RAM read, which lands in the cycle after that read.
   assign held_now   = held_src_ff ? (ram_rd_data & mask_ff) : held_ff;

   // Next state for one access.
   always_comb begin
      column_in   = column_ff;
      page_in     = page_ff;
      start_in    = start_ff;
      contrast_in = contrast_ff;
      light_in    = light_ff;
      dark_in     = dark_ff;
      pending_in  = pending_ff;
      max_in      = max_ff;
      mode_in     = mode_ff;
      rmw_in      = rmw_ff;
      saved_in    = saved_ff;
      dummy_in    = dummy_ff;
      held_in     = held_ff;
      held_src_in = held_src_ff;
      mask_in     = mask_ff;
      rdata_in    = 8'h00;
      rd_ram_in   = 1'b0;
      lv          = lcd_dp_pkg::contrast_levels(max_ff, contrast_ff);
      ram_req.wr_en = 1'b0;
      ram_req.rd_en = 1'b0;
      ram_req.addr  = lcd_dp_pkg::RAM_AW'({page_ff, addr_col});
      ram_req.wdata = wdata;

      if (pending_ff) begin
         // The access right after the contrast command supplies its value; a read sets full contrast.
         pending_in = 1'b0;
         if (op) begin
            lv          = lcd_dp_pkg::contrast_levels(max_ff, lcd_dp_pkg::CONTRAST_FULL);
            contrast_in = lcd_dp_pkg::CONTRAST_FULL;
            if (reg_sel) begin
               held_in     = 8'h00;
               held_src_in = 1'b0;
            end
         end else begin
            lv          = lcd_dp_pkg::contrast_levels(max_ff, wdata[5:0]);
            contrast_in = wdata[5:0];
         end
         light_in = lv.light;
         dark_in  = lv.dark;
      end else if (op) begin
         if (!reg_sel) begin
            // Status read.
            rdata_in = lcd_dp_pkg::STATUS_BASE |
                       (mode_ff.on ? lcd_dp_pkg::STATUS_ON : 8'h00);
         end else if (!dummy_ff && cpu_access) begin
            // Real data read: the byte comes from the RAM port next cycle.
            ram_req.rd_en = accept;
            rd_ram_in     = 1'b1;
            held_src_in   = 1'b1;
            if (!page_valid) begin
               mask_in = lcd_dp_pkg::MASK_NONE;
            end else if (page_ff[3]) begin
               mask_in = lcd_dp_pkg::MASK_ICON_PAGE;
            end else begin
               mask_in = lcd_dp_pkg::MASK_ALL;
            end
            if (!rmw_ff) begin
               column_in = col_next;
               dummy_in  = 1'b1;
            end
         end else begin
            // Dummy read, or a read without cpu_access, returns the held byte.
            dummy_in = 1'b0;
            rdata_in = held_now;
         end
      end else if (!reg_sel) begin
         case (wdata) inside
            [lcd_dp_pkg::CMD_COL_LO_FIRST:lcd_dp_pkg::CMD_COL_LO_LAST]: begin
               if (!rmw_ff) begin
                  column_in = {column_ff[7:4], wdata[3:0]};
                  dummy_in  = 1'b1;
               end
            end
            [lcd_dp_pkg::CMD_COL_HI_FIRST:lcd_dp_pkg::CMD_COL_HI_LAST]: begin
               if (!rmw_ff) begin
                  column_in = {wdata[3:0], column_ff[3:0]};
                  dummy_in  = 1'b1;
               end
            end
            [lcd_dp_pkg::CMD_START_FIRST:lcd_dp_pkg::CMD_START_LAST]: begin
               start_in = wdata[5:0];
            end
            lcd_dp_pkg::CMD_CONTRAST: begin
               pending_in = 1'b1;
            end
            lcd_dp_pkg::CMD_SEG_NORMAL, lcd_dp_pkg::CMD_SEG_REVERSE: begin
               mode_in.seg = wdata[0];
            end
            lcd_dp_pkg::CMD_MAX_OFF, lcd_dp_pkg::CMD_MAX_ON: begin
               max_in   = wdata[0];
               lv       = lcd_dp_pkg::contrast_levels(wdata[0], contrast_ff);
               light_in = lv.light;
               dark_in  = lv.dark;
            end
            lcd_dp_pkg::CMD_SET_OFF, lcd_dp_pkg::CMD_SET_ON: begin
               mode_in.set = wdata[0];
            end
            lcd_dp_pkg::CMD_INV_OFF, lcd_dp_pkg::CMD_INV_ON: begin
               mode_in.inv = wdata[0];
            end
            lcd_dp_pkg::CMD_DISP_OFF, lcd_dp_pkg::CMD_DISP_ON: begin
               mode_in.on = wdata[0];
            end
            [lcd_dp_pkg::CMD_PAGE_FIRST:lcd_dp_pkg::CMD_PAGE_LAST]: begin
               page_in = wdata[3:0];
            end
            [lcd_dp_pkg::CMD_ROWS_FIRST:lcd_dp_pkg::CMD_ROWS_LAST]: begin
               mode_in.rows = wdata[3];
            end
            lcd_dp_pkg::CMD_RMW_START: begin
               rmw_in   = 1'b1;
               saved_in = column_ff;
            end
            lcd_dp_pkg::CMD_SOFT_RESET: begin
               // Levels use the max contrast flag as it stood before the reset.
               pending_in  = 1'b0;
               lv          = lcd_dp_pkg::contrast_levels(max_ff, lcd_dp_pkg::CONTRAST_SOFT);
               contrast_in = lcd_dp_pkg::CONTRAST_SOFT;
               light_in    = lv.light;
               dark_in     = lv.dark;
               column_in   = 8'h00;
               start_in    = 6'h00;
               max_in      = 1'b0;
               mode_in     = '0;
               page_in     = 4'h0;
               rmw_in      = 1'b0;
               dummy_in    = 1'b1;
               saved_in    = 8'h00;
            end
            lcd_dp_pkg::CMD_RMW_END: begin
               rmw_in    = 1'b0;
               column_in = saved_ff;
            end
            default: begin
            end
         endcase
      end else begin
         // Display data write; pages past the RAM drop the byte.
         ram_req.wr_en = accept & page_valid;
         column_in     = col_next;
         dummy_in      = 1'b1;
      end
   end

   // Control and settings registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff   <= 8'h00;
         page_ff     <= 4'h0;
         start_ff    <= 6'h00;
         contrast_ff <= lcd_dp_pkg::CONTRAST_RESET;
         light_ff    <= lcd_dp_pkg::LIGHT_TABLE[lcd_dp_pkg::CONTRAST_RESET];
         dark_ff     <= lcd_dp_pkg::DARK_TABLE[lcd_dp_pkg::CONTRAST_RESET];
         pending_ff  <= 1'b0;
         max_ff      <= 1'b0;
         mode_ff     <= '0;
         rmw_ff      <= 1'b0;
         saved_ff    <= 8'h00;
         dummy_ff    <= 1'b0;
         held_ff     <= lcd_dp_pkg::HELD_RESET;
         held_src_ff <= 1'b0;
         rd_ram_ff   <= 1'b0;
      end else if (accept) begin
         column_ff   <= column_in;
         page_ff     <= page_in;
         start_ff    <= start_in;
         contrast_ff <= contrast_in;
         light_ff    <= light_in;
         dark_ff     <= dark_in;
         pending_ff  <= pending_in;
         max_ff      <= max_in;
         mode_ff     <= mode_in;
         rmw_ff      <= rmw_in;
         saved_ff    <= saved_in;
         dummy_ff    <= dummy_in;
         held_ff     <= held_in;
         held_src_ff <= held_src_in;
         rd_ram_ff   <= rd_ram_in;
      end
   end

   // Payload registers of the result.
   always_ff @(posedge clock) begin
      if (accept) begin
         mask_ff  <= mask_in;
         rdata_ff <= rdata_in;
      end
   end

   assign rdata            = rd_ram_ff ? (ram_rd_data & mask_ff) : rdata_ff;
   assign contrast_level   = contrast_ff;
   assign light_level      = light_ff;
   assign dark_level       = dark_ff;
   assign display_enabled  = mode_ff.on;
   assign first_line       = start_ff;
   assign segment_reversed = mode_ff.seg;
   assign rows_reversed    = mode_ff.rows;
   assign invert_all       = mode_ff.inv;
   assign force_all        = mode_ff.set;

endmodule

### sv/lcd_controller_command_data_port.sv
// LCD controller command and data port, top level: request/response handshake.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle unless the result stalls or the RAM is busy;
// the display RAM port takes one access a cycle. Reset: synchronous; afterwards
// req_tready stays low while the display RAM is zero filled one entry per cycle
// (PAGE_COUNT * 256 entries). Depends on lcd_dp_pkg, lcd_dp_ram and lcd_dp_core.
module lcd_controller_command_data_port (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] wdata
   input  logic [2:0]  req_tuser,   // [0] op, [1] reg_sel, [2] cpu_access
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] rdata, [13:8] contrast_level, [21:14] light_level, [29:22] dark_level,
   // [30] display_enabled, [36:31] first_line, [37] segment_reversed,
   // [38] rows_reversed, [39] invert_all, [40] force_all, [47:41] zero
   output logic [47:0] rsp_tdata
);

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    accept;
   logic                    ram_ready;
   logic [7:0]              ram_rd_data;
   lcd_dp_pkg::ram_req_type ram_req;

   logic [7:0] rdata;
   logic [5:0] contrast_level;
   logic [7:0] light_level;
   logic [7:0] dark_level;
   logic       display_enabled;
   logic [5:0] first_line;
   logic       segment_reversed;
   logic       rows_reversed;
   logic       invert_all;
   logic       force_all;

   // A request enters when the RAM is ready and the result slot is free or being emptied.
   assign req_tready   = ram_ready & (~rsp_valid_ff | rsp_tready);
   assign accept       = req_tvalid & req_tready;
   assign rsp_valid_in = accept | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   lcd_dp_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .req     (ram_req),
      .rd_data (ram_rd_data),
      .ready   (ram_ready)
   );

   lcd_dp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .op               (req_tuser[0]),
      .reg_sel          (req_tuser[1]),
      .wdata            (req_tdata),
      .cpu_access       (req_tuser[2]),
      .ram_rd_data      (ram_rd_data),
      .ram_req          (ram_req),
      .rdata            (rdata),
      .contrast_level   (contrast_level),
      .light_level      (light_level),
      .dark_level       (dark_level),
      .display_enabled  (display_enabled),
      .first_line       (first_line),
      .segment_reversed (segment_reversed),
      .rows_reversed    (rows_reversed),
      .invert_all       (invert_all),
      .force_all        (force_all)
   );

   // Pack the result fields from the lowest bit up.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'h00, force_all, invert_all, rows_reversed, segment_reversed,
                        first_line, display_enabled, dark_level, light_level,
                        contrast_level, rdata};

endmodule

### tb/sv/lcd_controller_command_data_port_tb.sv
// Self-checking testbench for the LCD controller command and data port.
// Holds its own predictor of the port state and display RAM; depends on lcd_dp_pkg
// and the lcd_controller_command_data_port RTL.
`timescale 1ns / 1ps

module lcd_controller_command_data_port_tb;

   // Access kinds and ports as carried in req_tuser.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_READ   = 1'b1;
   localparam logic PORT_CTRL = 1'b0;
   localparam logic PORT_DATA = 1'b1;
   localparam logic [7:0] CMD_UNUSED = 8'hFF;
   localparam int CYCLE_LIMIT = 300000;
   localparam int TAIL_CYCLES = 4;

   // Layout of rsp_tdata, highest field first.
   typedef struct packed {
      logic [6:0] pad;
      logic       force_all;
      logic       invert_all;
      logic       rows_reversed;
      logic       segment_reversed;
      logic [5:0] first_line;
      logic       display_enabled;
      logic [7:0] dark_level;
      logic [7:0] light_level;
      logic [5:0] contrast_level;
      logic [7:0] rdata;
   } port_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;

   lcd_controller_command_data_port uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Predicted controller state.
   logic [7:0] dram_image [lcd_dp_pkg::RAM_DEPTH];
   logic [7:0] col_ptr;
   logic [3:0] page_ptr;
   logic [5:0] first_line_q;
   logic [5:0] contrast_q;
   logic [7:0] light_q;
   logic [7:0] dark_q;
   logic       contrast_pend;
   logic       max_flag;
   lcd_dp_pkg::mode_type mode;
   logic       rmw_on;
   logic [7:0] rmw_col;
   logic       dummy_pend;
   logic [7:0] held_byte;

   port_result_type pending_responses [$];

   int req_idle_pct;
   int rsp_stall_pct;
   int sent_count;
   int rsp_count;
   int mismatch_count;
   int cycle_count;
   int data_writes;
   int data_reads;
   int command_writes;
   int status_reads;

   // Clock: 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Run limit in case the handshake hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, pending_responses.size());
         $display("lcd_controller_command_data_port test failed");
         $finish;
      end
   end

   // Receiver back pressure, changed at the falling edge.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Light and dark levels follow the contrast unless max contrast is forced.
   task automatic load_contrast(input logic [5:0] value);
      contrast_q = value;
      if (max_flag) begin
         light_q = lcd_dp_pkg::MAX_LIGHT;
         dark_q  = lcd_dp_pkg::MAX_DARK;
      end else begin
         light_q = lcd_dp_pkg::LIGHT_TABLE[value];
         dark_q  = lcd_dp_pkg::DARK_TABLE[value];
      end
   endtask

   task automatic reset_model();
      for (int i = 0; i < lcd_dp_pkg::RAM_DEPTH; i++) dram_image[i] = 8'h00;
      col_ptr       = '0;
      page_ptr      = '0;
      first_line_q  = '0;
      contrast_pend = 1'b0;
      max_flag      = 1'b0;
      mode          = '0;
      rmw_on        = 1'b0;
      rmw_col       = '0;
      dummy_pend    = 1'b0;
      held_byte     = lcd_dp_pkg::HELD_RESET;
      load_contrast(lcd_dp_pkg::CONTRAST_RESET);
   endtask

   // RAM index of the current pointer; reverse segment mirrors the column.
   function automatic int ram_index();
      logic [7:0] addr_col;
      addr_col = mode.seg ? lcd_dp_pkg::LAST_COLUMN - col_ptr : col_ptr;
      return int'(page_ptr) * lcd_dp_pkg::PAGE_STRIDE + int'(addr_col);
   endfunction

   // Column increments wrap at 256 and then saturate at the last column.
   task automatic step_column();
      logic [7:0] next_col;
      next_col = col_ptr + 8'd1;
      col_ptr  = (next_col > lcd_dp_pkg::LAST_COLUMN) ? lcd_dp_pkg::LAST_COLUMN : next_col;
   endtask

   task automatic run_command(input logic [7:0] code);
      if (code <= lcd_dp_pkg::CMD_COL_LO_LAST) begin
         if (!rmw_on) begin
            col_ptr[3:0] = code[3:0];
            dummy_pend   = 1'b1;
         end
      end else if (code <= lcd_dp_pkg::CMD_COL_HI_LAST) begin
         if (!rmw_on) begin
            col_ptr[7:4] = code[3:0];
            dummy_pend   = 1'b1;
         end
      end else if (code >= lcd_dp_pkg::CMD_START_FIRST &&
                   code <= lcd_dp_pkg::CMD_START_LAST) begin
         first_line_q = code[5:0];
      end else if (code == lcd_dp_pkg::CMD_CONTRAST) begin
         contrast_pend = 1'b1;
      end else if (code == lcd_dp_pkg::CMD_SEG_NORMAL ||
                   code == lcd_dp_pkg::CMD_SEG_REVERSE) begin
         mode.seg = code[0];
      end else if (code == lcd_dp_pkg::CMD_MAX_OFF || code == lcd_dp_pkg::CMD_MAX_ON) begin
         max_flag = code[0];
         load_contrast(contrast_q);
      end else if (code == lcd_dp_pkg::CMD_SET_OFF || code == lcd_dp_pkg::CMD_SET_ON) begin
         mode.set = code[0];
      end else if (code == lcd_dp_pkg::CMD_INV_OFF || code == lcd_dp_pkg::CMD_INV_ON) begin
         mode.inv = code[0];
      end else if (code == lcd_dp_pkg::CMD_DISP_OFF || code == lcd_dp_pkg::CMD_DISP_ON) begin
         mode.on = code[0];
      end else if (code >= lcd_dp_pkg::CMD_PAGE_FIRST &&
                   code <= lcd_dp_pkg::CMD_PAGE_LAST) begin
         page_ptr = code[3:0];
      end else if (code >= lcd_dp_pkg::CMD_ROWS_FIRST &&
                   code <= lcd_dp_pkg::CMD_ROWS_LAST) begin
         mode.rows = code[3];
      end else if (code == lcd_dp_pkg::CMD_RMW_START) begin
         rmw_on  = 1'b1;
         rmw_col = col_ptr;
      end else if (code == lcd_dp_pkg::CMD_SOFT_RESET) begin
         // Levels use the max contrast flag as it stood before the reset.
         contrast_pend = 1'b0;
         load_contrast(lcd_dp_pkg::CONTRAST_SOFT);
         col_ptr      = '0;
         first_line_q = '0;
         max_flag     = 1'b0;
         mode         = '0;
         page_ptr     = '0;
         rmw_on       = 1'b0;
         dummy_pend   = 1'b1;
         rmw_col      = '0;
      end else if (code == lcd_dp_pkg::CMD_RMW_END) begin
         rmw_on  = 1'b0;
         col_ptr = rmw_col;
      end
   endtask

   // Applies one accepted request to the predicted state and builds its response.
   task automatic apply_access(input logic is_read, input logic to_data,
                               input logic [7:0] wd, input logic cpu,
                               output port_result_type want);
      logic [7:0] rd;
      rd = 8'h00;
      if (contrast_pend) begin
         // The request after the contrast command carries the contrast value.
         contrast_pend = 1'b0;
         if (is_read) begin
            load_contrast(lcd_dp_pkg::CONTRAST_FULL);
            if (to_data) held_byte = 8'h00;
         end else begin
            load_contrast(wd[5:0]);
         end
      end else if (is_read) begin
         if (!to_data) begin
            rd = lcd_dp_pkg::STATUS_BASE | (mode.on ? lcd_dp_pkg::STATUS_ON : 8'h00);
         end else begin
            if (!dummy_pend && cpu) begin
               held_byte = (page_ptr < lcd_dp_pkg::PAGE_COUNT) ? dram_image[ram_index()]
                                                               : 8'h00;
               if (page_ptr >= 4'd8) held_byte = held_byte & lcd_dp_pkg::MASK_ICON_PAGE;
               if (!rmw_on) begin
                  step_column();
                  dummy_pend = 1'b1;
               end
            end else begin
               dummy_pend = 1'b0;
            end
            rd = held_byte;
         end
      end else if (!to_data) begin
         run_command(wd);
      end else begin
         if (page_ptr < lcd_dp_pkg::PAGE_COUNT) dram_image[ram_index()] = wd;
         step_column();
         dummy_pend = 1'b1;
      end

      want                  = '0;
      want.rdata            = rd;
      want.contrast_level   = contrast_q;
      want.light_level      = light_q;
      want.dark_level       = dark_q;
      want.display_enabled  = mode.on;
      want.first_line       = first_line_q;
      want.segment_reversed = mode.seg;
      want.rows_reversed    = mode.rows;
      want.invert_all       = mode.inv;
      want.force_all        = mode.set;
   endtask

   // Drives one request from the falling edge and waits for it to be taken.
   task automatic send_access(input logic is_read, input logic to_data,
                              input logic [7:0] wd, input logic cpu);
      port_result_type want;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= wd;
      req_tuser  <= {cpu, to_data, is_read};
      do @(posedge clock); while (!req_tready);
      apply_access(is_read, to_data, wd, cpu, want);
      pending_responses.push_back(want);
      sent_count++;
      if (is_read && to_data) data_reads++;
      else if (is_read) status_reads++;
      else if (to_data) data_writes++;
      else command_writes++;
   endtask

   task automatic send_command(input logic [7:0] code);
      send_access(OP_WRITE, PORT_CTRL, code, 1'b1);
   endtask

   task automatic set_position(input logic [3:0] page, input logic [7:0] column);
      send_command(lcd_dp_pkg::CMD_PAGE_FIRST | {4'h0, page});
      send_command(lcd_dp_pkg::CMD_COL_HI_FIRST | {4'h0, column[7:4]});
      send_command(lcd_dp_pkg::CMD_COL_LO_FIRST | {4'h0, column[3:0]});
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Mismatch in %s of response %0d: expected 0x%02h, got 0x%02h",
                     name, rsp_count, want, got);
      end
   endtask

   // Each response taken is compared with the oldest prediction.
   always @(posedge clock) begin : check_response
      port_result_type got;
      port_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Response 0x%012h arrived with no request outstanding.", rsp_tdata);
         end else begin
            want = pending_responses.pop_front();
            check_field("rdata", want.rdata, got.rdata);
            check_field("contrast_level", 8'(want.contrast_level), 8'(got.contrast_level));
            check_field("light_level", want.light_level, got.light_level);
            check_field("dark_level", want.dark_level, got.dark_level);
            check_field("display_enabled", 8'(want.display_enabled),
                        8'(got.display_enabled));
            check_field("first_line", 8'(want.first_line), 8'(got.first_line));
            check_field("segment_reversed", 8'(want.segment_reversed),
                        8'(got.segment_reversed));
            check_field("rows_reversed", 8'(want.rows_reversed), 8'(got.rows_reversed));
            check_field("invert_all", 8'(want.invert_all), 8'(got.invert_all));
            check_field("force_all", 8'(want.force_all), 8'(got.force_all));
            check_field("padding", 8'(want.pad), 8'(got.pad));
         end
         rsp_count++;
      end
   end

   // Status reads, the access after the contrast command as a data write, a data read and a command, and max contrast.
   task automatic test_status_and_contrast();
      send_access(OP_READ, PORT_CTRL, 8'h00, 1'b1);
      send_command(lcd_dp_pkg::CMD_DISP_ON);
      send_access(OP_READ, PORT_CTRL, 8'hFF, 1'b0);
      send_command(lcd_dp_pkg::CMD_CONTRAST);
      send_access(OP_WRITE, PORT_DATA, 8'hFF, 1'b1);
      send_command(lcd_dp_pkg::CMD_CONTRAST);
      send_access(OP_READ, PORT_DATA, 8'h00, 1'b1);
      send_command(lcd_dp_pkg::CMD_MAX_ON);
      send_command(lcd_dp_pkg::CMD_CONTRAST);
      send_command(lcd_dp_pkg::CMD_COL_LO_FIRST);
      send_command(lcd_dp_pkg::CMD_START_LAST);
      send_command(lcd_dp_pkg::CMD_ROWS_LAST);
      send_command(lcd_dp_pkg::CMD_SET_ON);
      send_command(lcd_dp_pkg::CMD_INV_ON);
   endtask

   // Icon page masking, column saturation and wrap, and reverse segment addressing.
   task automatic test_column_and_page_edges();
      set_position(4'(lcd_dp_pkg::CMD_PAGE_LAST - lcd_dp_pkg::CMD_PAGE_FIRST),
                   lcd_dp_pkg::LAST_COLUMN);
      send_access(OP_WRITE, PORT_DATA, 8'hFF, 1'b1);
      send_command(lcd_dp_pkg::CMD_COL_LO_FIRST | {4'h0, lcd_dp_pkg::LAST_COLUMN[3:0]});
      send_access(OP_READ, PORT_DATA, 8'h00, 1'b1);
      send_access(OP_READ, PORT_DATA, 8'h00, 1'b1);
      send_command(lcd_dp_pkg::CMD_SEG_REVERSE);
      send_access(OP_WRITE, PORT_DATA, 8'h5A, 1'b1);
      send_command(lcd_dp_pkg::CMD_SEG_NORMAL);
      send_command(lcd_dp_pkg::CMD_COL_HI_LAST);
      send_command(lcd_dp_pkg::CMD_COL_LO_LAST);
      send_access(OP_WRITE, PORT_DATA, 8'hA5, 1'b1);
      send_access(OP_WRITE, PORT_DATA, 8'h00, 1'b1);
   endtask

   // Read-modify-write keeps the column on reads; soft reset and an unused code.
   task automatic test_rmw_and_soft_reset();
      send_command(lcd_dp_pkg::CMD_RMW_START);
      send_access(OP_READ, PORT_DATA, 8'h00, 1'b0);
      send_access(OP_READ, PORT_DATA, 8'h00, 1'b1);
      send_access(OP_WRITE, PORT_DATA, 8'h3C, 1'b1);
      send_command(lcd_dp_pkg::CMD_RMW_END);
      send_command(lcd_dp_pkg::CMD_SOFT_RESET);
      send_command(CMD_UNUSED);
      send_access(OP_READ, PORT_CTRL, 8'h00, 1'b1);
   endtask

   // One random mode or settings command, unused codes among them.
   task automatic send_mode_command();
      logic [7:0] code;
      case ($urandom_range(8))
         0: code = lcd_dp_pkg::CMD_START_FIRST + 8'($urandom_range(63));
         1: code = lcd_dp_pkg::CMD_SEG_NORMAL | 8'($urandom_range(1));
         2: code = lcd_dp_pkg::CMD_MAX_OFF | 8'($urandom_range(1));
         3: code = lcd_dp_pkg::CMD_SET_OFF | 8'($urandom_range(1));
         4: code = lcd_dp_pkg::CMD_INV_OFF | 8'($urandom_range(1));
         5: code = lcd_dp_pkg::CMD_DISP_OFF | 8'($urandom_range(1));
         6: code = lcd_dp_pkg::CMD_ROWS_FIRST + 8'($urandom_range(15));
         7: code = lcd_dp_pkg::CMD_PAGE_FIRST + 8'($urandom_range(8));
         default: code = 8'($urandom_range(255));
      endcase
      send_command(code);
   endtask

   // Mostly well-formed write, read-back and settings sequences, some noise.
   task automatic test_random_traffic(input int item_target);
      int first_item;
      int kind;
      int burst;
      logic [3:0] page;
      logic [7:0] column;
      first_item = sent_count;
      while (sent_count - first_item < item_target) begin
         kind   = $urandom_range(99);
         burst  = $urandom_range(1, 6);
         page   = 4'($urandom_range(8));
         column = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(131));
         if (kind < 30) begin
            // Write a burst, then read it back with the leading dummy read.
            set_position(page, column);
            repeat (burst) send_access(OP_WRITE, PORT_DATA, 8'($urandom_range(255)), 1'b1);
            set_position(page, column);
            repeat (2 * burst + 1)
               send_access(OP_READ, PORT_DATA, 8'($urandom_range(255)),
                           $urandom_range(9) != 0);
         end else if (kind < 45) begin
            set_position(page, column);
            repeat (burst) send_access(OP_WRITE, PORT_DATA, 8'($urandom_range(255)), 1'b1);
         end else if (kind < 55) begin
            if ($urandom_range(3) == 0)
               send_command(lcd_dp_pkg::CMD_MAX_OFF | 8'($urandom_range(1)));
            send_command(lcd_dp_pkg::CMD_CONTRAST);
            send_access(1'($urandom_range(1)), 1'($urandom_range(1)),
                        8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (kind < 70) begin
            repeat ($urandom_range(1, 3)) send_mode_command();
         end else if (kind < 80) begin
            set_position(page, column);
            send_command(lcd_dp_pkg::CMD_RMW_START);
            repeat (burst) begin
               send_access(OP_READ, PORT_DATA, 8'h00, 1'b1);
               send_access(OP_READ, PORT_DATA, 8'h00, 1'b1);
               send_access(OP_WRITE, PORT_DATA, 8'($urandom_range(255)), 1'b1);
            end
            if ($urandom_range(4) != 0) send_command(lcd_dp_pkg::CMD_RMW_END);
         end else if (kind < 83) begin
            send_command(lcd_dp_pkg::CMD_SOFT_RESET);
         end else if (kind < 88) begin
            send_access(OP_READ, 1'($urandom_range(1)), 8'($urandom_range(255)),
                        1'($urandom_range(1)));
         end else begin
            send_access(1'($urandom_range(1)), 1'($urandom_range(1)),
                        8'($urandom_range(255)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      req_idle_pct   = 11;
      rsp_stall_pct  = 62;
      sent_count     = 0;
      rsp_count      = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      data_writes    = 0;
      data_reads     = 0;
      command_writes = 0;
      status_reads   = 0;
      reset_model();
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_status_and_contrast();
      test_column_and_page_edges();
      test_rmw_and_soft_reset();
      test_random_traffic(135);
      req_idle_pct  = 62;
      rsp_stall_pct = 11;
      test_random_traffic(135);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_traffic(135);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d data writes, %0d data reads, %0d commands,",
               sent_count, data_writes, data_reads, command_writes);
      $display("%0d status reads); checked %0d responses over three pacing phases.",
               status_reads, rsp_count);
      if (mismatch_count == 0) begin
         $display("lcd_controller_command_data_port test passed");
      end else begin
         $display("Found %0d field mismatches.", mismatch_count);
         $display("lcd_controller_command_data_port test failed");
      end
      $finish;
   end

endmodule

### filelist.f
sv/lcd_dp_pkg.sv
sv/lcd_dp_ram.sv
sv/lcd_dp_core.sv
sv/lcd_controller_command_data_port.sv
tb/sv/lcd_controller_command_data_port_tb.sv
